@@ sv/tfn_pkg.sv @@
// shared constants for the triangle face normal block
package tfn_pkg;

    // default coordinate and normal widths
    localparam int COORD_BITS_DEF  = 24;
    localparam int NORMAL_BITS_DEF = 16;

    // widest edge kept before the cross product
    localparam int EDGE_BITS_MAX = 30;

    // magnitudes are scaled to stay below 2^MAG_BITS before the length is taken
    localparam int MAG_BITS = 30;

endpackage

@@ sv/tfn_in_if.sv @@
// request channel carrying the three corners of one triangle
interface tfn_in_if
    import tfn_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] corner_a_x;
    logic signed [COORD_BITS-1:0] corner_a_y;
    logic signed [COORD_BITS-1:0] corner_a_z;
    logic signed [COORD_BITS-1:0] corner_b_x;
    logic signed [COORD_BITS-1:0] corner_b_y;
    logic signed [COORD_BITS-1:0] corner_b_z;
    logic signed [COORD_BITS-1:0] corner_c_x;
    logic signed [COORD_BITS-1:0] corner_c_y;
    logic signed [COORD_BITS-1:0] corner_c_z;

    modport source
    (
        output valid,
        output corner_a_x, corner_a_y, corner_a_z,
        output corner_b_x, corner_b_y, corner_b_z,
        output corner_c_x, corner_c_y, corner_c_z,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  corner_a_x, corner_a_y, corner_a_z,
        input  corner_b_x, corner_b_y, corner_b_z,
        input  corner_c_x, corner_c_y, corner_c_z,
        output ready
    );
endinterface

@@ sv/tfn_out_if.sv @@
// result channel carrying one unit face normal
interface tfn_out_if
    import tfn_pkg::*;
#(
    parameter int NORMAL_BITS = NORMAL_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [NORMAL_BITS-1:0] normal_x;
    logic signed [NORMAL_BITS-1:0] normal_y;
    logic signed [NORMAL_BITS-1:0] normal_z;
    logic                          degenerate;

    modport source
    (
        output valid,
        output normal_x, normal_y, normal_z, degenerate,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  normal_x, normal_y, normal_z, degenerate,
        output ready
    );
endinterface

@@ sv/triangle_face_normal.sv @@
// triangle_face_normal: pipelined fixed point face normal of one triangle
//
// Takes one triangle request per clock unless the skid register is full
// and returns its unit face normal in Q1.(NORMAL_BITS-1), giving one result
// per clock when the sink keeps up.
// The pipe depth is set by the square root, which resolves one root bit per
// stage over 31 stages, and by the three parallel restoring dividers, which
// resolve one quotient bit per stage over NORMAL_BITS-1 stages. The front end
// takes the edges, the edge products (one multiplier each), the cross
// product, the magnitudes, the scaling to 30 bits and the squares each in a
// stage of its own. Every stage moves on a common enable that drops only when
// the skid register behind the output register is full, so ready comes
// straight from a flop and a stalled sink loses and repeats nothing. A zero
// cross product gives a zero normal with the degenerate flag set.
module triangle_face_normal
    import tfn_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int NORMAL_BITS = NORMAL_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    tfn_in_if.sink    corners,
    tfn_out_if.source normal
);

    // datapath widths
    localparam int DW         = COORD_BITS + 1;
    localparam int EDGE_SHIFT = (DW > EDGE_BITS_MAX) ? DW - EDGE_BITS_MAX : 0;
    localparam int EW         = DW - EDGE_SHIFT;
    localparam int PW         = 2 * EW;
    localparam int NW         = PW + 1;
    localparam int KW         = $clog2(NW + 1);
    localparam int MW         = MAG_BITS;
    localparam int SQW        = 2 * MW + 2;
    localparam int RW         = MW + 1;
    localparam int Q          = NORMAL_BITS - 1;
    localparam int NUMW       = RW + Q;
    localparam int NB         = NORMAL_BITS;
    localparam int TOTAL      = 8 + RW + Q;

    localparam logic [Q-1:0]  S_VAL    = {Q{1'b1}};
    localparam logic [NB-1:0] NEG_FULL = {1'b1, {(NB-1){1'b0}}};

    typedef struct packed {
        logic [2:0][MW-1:0] m;
        logic [2:0]         sgn;
        logic               dgn;
    } tfn_carry_t;

    typedef struct packed {
        logic [NB-1:0] x;
        logic [NB-1:0] y;
        logic [NB-1:0] z;
        logic          dgn;
    } tfn_result_t;

    logic             en;
    logic [TOTAL-1:0] vld_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    tfn_result_t      out_reg;
    tfn_result_t      skid_reg;
    tfn_result_t      res_next;

    // the whole pipe advances unless the skid register is holding a result
    assign en            = !skid_valid_reg;
    assign corners.ready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[TOTAL-2:0], corners.valid};
        end
    end

    // stage 1: edge vectors, scaled down when the coordinates are very wide
    logic signed [COORD_BITS-1:0] ca [3];
    logic signed [COORD_BITS-1:0] cb [3];
    logic signed [COORD_BITS-1:0] cc [3];
    logic signed [DW-1:0]         d0 [3];
    logic signed [DW-1:0]         d1 [3];
    logic signed [EW-1:0]         e0_reg [3];
    logic signed [EW-1:0]         e1_reg [3];

    always_comb
    begin
        ca[0] = corners.corner_a_x;
        ca[1] = corners.corner_a_y;
        ca[2] = corners.corner_a_z;
        cb[0] = corners.corner_b_x;
        cb[1] = corners.corner_b_y;
        cb[2] = corners.corner_b_z;
        cc[0] = corners.corner_c_x;
        cc[1] = corners.corner_c_y;
        cc[2] = corners.corner_c_z;
        for (int i = 0; i < 3; i++)
        begin
            d0[i] = DW'(cb[i]) - DW'(ca[i]);
            d1[i] = DW'(cc[i]) - DW'(ca[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e0_reg[i] <= EW'(d0[i] >>> EDGE_SHIFT);
                e1_reg[i] <= EW'(d1[i] >>> EDGE_SHIFT);
            end
        end
    end

    // stage 2: the edge products
    logic signed [PW-1:0] p_reg [6];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= PW'(e0_reg[1]) * PW'(e1_reg[2]);
            p_reg[1] <= PW'(e0_reg[2]) * PW'(e1_reg[1]);
            p_reg[2] <= PW'(e0_reg[2]) * PW'(e1_reg[0]);
            p_reg[3] <= PW'(e0_reg[0]) * PW'(e1_reg[2]);
            p_reg[4] <= PW'(e0_reg[0]) * PW'(e1_reg[1]);
            p_reg[5] <= PW'(e0_reg[1]) * PW'(e1_reg[0]);
        end
    end

    // stage 3: cross product
    logic signed [NW-1:0] n_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                n_reg[i] <= NW'(p_reg[2*i]) - NW'(p_reg[2*i+1]);
            end
        end
    end

    // stage 4: sign and magnitude, zero test
    logic [NW-1:0] mag_reg [3];
    logic [2:0]    sgn4_reg;
    logic          dgn4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i]  <= n_reg[i][NW-1] ? (~n_reg[i] + 1'b1) : n_reg[i];
                sgn4_reg[i] <= n_reg[i][NW-1];
            end
            dgn4_reg <= (n_reg[0] == '0) && (n_reg[1] == '0) && (n_reg[2] == '0);
        end
    end

    // stage 5: shift all magnitudes so the largest stays below 2^MW
    logic [NW-1:0] mag_or;
    logic [KW-1:0] top_pos;
    logic [KW-1:0] k_sh;
    tfn_carry_t    c5_reg;

    always_comb
    begin
        mag_or  = mag_reg[0] | mag_reg[1] | mag_reg[2];
        top_pos = '0;
        for (int b = 0; b < NW; b++)
        begin
            if (mag_or[b])
            begin
                top_pos = KW'(b + 1);
            end
        end
        k_sh = (int'(top_pos) > MW) ? KW'(int'(top_pos) - MW) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                c5_reg.m[i] <= MW'(mag_reg[i] >> k_sh);
            end
            c5_reg.sgn <= sgn4_reg;
            c5_reg.dgn <= dgn4_reg;
        end
    end

    // stage 6: squares
    logic [2*MW-1:0] sq_reg [3];
    tfn_carry_t      c6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= (2*MW)'(c5_reg.m[i]) * (2*MW)'(c5_reg.m[i]);
            end
            c6_reg <= c5_reg;
        end
    end

    // stage 7 and square root pipe: one root bit per stage
    logic [SQW-1:0] rt_v_reg   [0:RW];
    logic [SQW-1:0] rt_res_reg [0:RW];
    tfn_carry_t     rt_c_reg   [0:RW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rt_v_reg[0]   <= SQW'(sq_reg[0]) + SQW'(sq_reg[1]) + SQW'(sq_reg[2]);
            rt_res_reg[0] <= '0;
            rt_c_reg[0]   <= c6_reg;
        end
    end

    for (genvar j = 0; j < RW; j++)
    begin : g_root
        localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (RW - 1 - j));
        logic [SQW-1:0] trial;
        logic [SQW-1:0] v_next;
        logic [SQW-1:0] res_nx;

        always_comb
        begin
            trial = rt_res_reg[j] + BIT;
            if (rt_v_reg[j] >= trial)
            begin
                v_next = rt_v_reg[j] - trial;
                res_nx = (rt_res_reg[j] >> 1) + BIT;
            end
            else
            begin
                v_next = rt_v_reg[j];
                res_nx = rt_res_reg[j] >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_v_reg[j+1]   <= v_next;
                rt_res_reg[j+1] <= res_nx;
                rt_c_reg[j+1]   <= rt_c_reg[j];
            end
        end
    end

    // numerator stage: m * one + len / 2
    logic [RW-1:0]   len_raw;
    logic [RW-1:0]   len_fix;
    logic [NUMW-1:0] num [3];

    logic [RW-1:0] dv_l_reg  [0:Q];
    logic [RW-1:0] dv_r_reg  [0:Q][3];
    logic [Q-1:0]  dv_lo_reg [0:Q][3];
    logic [Q-1:0]  dv_q_reg  [0:Q][3];
    logic [2:0]    dv_s_reg  [0:Q];
    logic          dv_d_reg  [0:Q];

    always_comb
    begin
        len_raw = rt_res_reg[RW][RW-1:0];
        len_fix = (len_raw == '0) ? RW'(1) : len_raw;
        for (int i = 0; i < 3; i++)
        begin
            num[i] = NUMW'(rt_c_reg[RW].m[i]) * NUMW'(S_VAL) + NUMW'(len_fix >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_l_reg[0] <= len_fix;
            for (int i = 0; i < 3; i++)
            begin
                dv_r_reg[0][i]  <= num[i][NUMW-1:Q];
                dv_lo_reg[0][i] <= num[i][Q-1:0];
                dv_q_reg[0][i]  <= '0;
            end
            dv_s_reg[0] <= rt_c_reg[RW].sgn;
            dv_d_reg[0] <= rt_c_reg[RW].dgn;
        end
    end

    // restoring divider pipe: one quotient bit per stage for each component
    for (genvar s = 0; s < Q; s++)
    begin : g_div
        logic [RW:0]   trial [3];
        logic [RW:0]   diff  [3];
        logic [RW-1:0] r_nx  [3];
        logic [Q-1:0]  q_nx  [3];

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                trial[i] = {dv_r_reg[s][i], dv_lo_reg[s][i][Q-1-s]};
                diff[i]  = trial[i] - {1'b0, dv_l_reg[s]};
                if (trial[i] >= {1'b0, dv_l_reg[s]})
                begin
                    r_nx[i] = diff[i][RW-1:0];
                    q_nx[i] = {dv_q_reg[s][i][Q-2:0], 1'b1};
                end
                else
                begin
                    r_nx[i] = trial[i][RW-1:0];
                    q_nx[i] = {dv_q_reg[s][i][Q-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_l_reg[s+1] <= dv_l_reg[s];
                for (int i = 0; i < 3; i++)
                begin
                    dv_r_reg[s+1][i]  <= r_nx[i];
                    dv_lo_reg[s+1][i] <= dv_lo_reg[s][i];
                    dv_q_reg[s+1][i]  <= q_nx[i];
                end
                dv_s_reg[s+1] <= dv_s_reg[s];
                dv_d_reg[s+1] <= dv_d_reg[s];
            end
        end
    end

    // sign restore; the quotient never exceeds one, so no clamp is needed
    logic [NB-1:0] q_ext [3];
    logic [NB-1:0] comp  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_ext[i] = {1'b0, dv_q_reg[Q][i]};
            if (dv_d_reg[Q])
            begin
                comp[i] = '0;
            end
            else
            begin
                comp[i] = dv_s_reg[Q][i] ? (~q_ext[i] + 1'b1) : q_ext[i];
            end
        end
        res_next.x   = comp[0];
        res_next.y   = comp[1];
        res_next.z   = comp[2];
        res_next.dgn = dv_d_reg[Q];
    end

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!skid_valid_reg)
        begin
            if (out_valid_reg && !normal.ready)
            begin
                skid_valid_reg <= vld_reg[TOTAL-1];
            end
            else
            begin
                out_valid_reg <= vld_reg[TOTAL-1];
            end
        end
        else if (normal.ready)
        begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            if (out_valid_reg && !normal.ready)
            begin
                skid_reg <= res_next;
            end
            else
            begin
                out_reg <= res_next;
            end
        end
        else if (normal.ready)
        begin
            out_reg <= skid_reg;
        end
    end

    assign normal.valid      = out_valid_reg;
    assign normal.normal_x   = out_reg.x;
    assign normal.normal_y   = out_reg.y;
    assign normal.normal_z   = out_reg.z;
    assign normal.degenerate = out_reg.dgn;

    // a held skid result always has an output result in front of it
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full with output register empty");

    // the skid only fills when the output was stalled
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !normal.ready))
        else $error("skid register filled without a stall");

    // a degenerate triangle gives a zero normal
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (normal.valid && normal.degenerate) |->
        (normal.normal_x == '0 && normal.normal_y == '0 && normal.normal_z == '0))
        else $error("degenerate result with nonzero normal");

    // unit components stay within plus and minus one
    a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
        normal.valid |->
        (normal.normal_x != NEG_FULL && normal.normal_y != NEG_FULL &&
         normal.normal_z != NEG_FULL))
        else $error("normal component beyond unit range");

endmodule

@@ tb/tb.sv @@
// testbench for triangle_face_normal with a scoreboard class and handshake tasks
`timescale 1ns / 1ps

module tb;
    import tfn_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int NB = NORMAL_BITS_DEF;
    // shift applied to the edges when the coordinates are wider than 29 bits
    localparam int EDGE_SHIFT = (CB > 29) ? CB - 29 : 0;
    // value that stands for one in the normal format
    localparam longint UNIT = (longint'(1) << (NB - 1)) - 1;
    localparam int RANDOM_ITEMS = 1800;
    localparam int DRAIN_CYCLES = 39 + NB + 10;

    typedef logic signed [CB-1:0] coord_t;
    typedef logic signed [NB-1:0] norm_t;

    typedef struct {
        coord_t p[9];
    } triangle_t;

    typedef struct {
        norm_t nx;
        norm_t ny;
        norm_t nz;
        logic  degenerate;
    } face_normal_t;

    class normal_scoreboard;
        face_normal_t pending_normals[$];
        int mismatches;
        int unexpected;
        int checked;
        int degenerate_seen;

        function new();
            mismatches = 0;
            unexpected = 0;
            checked = 0;
            degenerate_seen = 0;
        endfunction

        // truncated integer square root
        function automatic bit [63:0] root_floor(bit [63:0] v);
            bit [63:0] res;
            bit [63:0] b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        function automatic face_normal_t face_normal(triangle_t t);
            face_normal_t r;
            longint c[9];
            longint e0[3];
            longint e1[3];
            longint n[3];
            bit [63:0] m[3];
            bit [63:0] len;
            bit [63:0] q;
            norm_t o[3];
            int k;
            for (int i = 0; i < 9; i++)
                c[i] = longint'(t.p[i]);
            for (int i = 0; i < 3; i++)
            begin
                e0[i] = (c[3+i] - c[i]) >>> EDGE_SHIFT;
                e1[i] = (c[6+i] - c[i]) >>> EDGE_SHIFT;
            end
            n[0] = e0[1] * e1[2] - e0[2] * e1[1];
            n[1] = e0[2] * e1[0] - e0[0] * e1[2];
            n[2] = e0[0] * e1[1] - e0[1] * e1[0];
            if (n[0] == 0 && n[1] == 0 && n[2] == 0)
            begin
                r.nx = '0;
                r.ny = '0;
                r.nz = '0;
                r.degenerate = 1'b1;
                return r;
            end
            for (int i = 0; i < 3; i++)
                m[i] = (n[i] < 0) ? 64'(-n[i]) : 64'(n[i]);
            k = 0;
            while (((m[0] | m[1] | m[2]) >> k) >= (64'd1 << MAG_BITS))
                k++;
            for (int i = 0; i < 3; i++)
                m[i] = m[i] >> k;
            len = root_floor(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
            if (len == 0)
                len = 1;
            for (int i = 0; i < 3; i++)
            begin
                q = (m[i] * 64'(UNIT) + (len >> 1)) / len;
                if (q > 64'(UNIT))
                    q = 64'(UNIT);
                // a magnitude that rounds to zero comes out as plain zero
                o[i] = (n[i] < 0) ? norm_t'(-q) : norm_t'(q);
            end
            r.nx = o[0];
            r.ny = o[1];
            r.nz = o[2];
            r.degenerate = 1'b0;
            return r;
        endfunction

        function void note_request(triangle_t t);
            pending_normals.push_back(face_normal(t));
        endfunction

        function void check_normal(face_normal_t got);
            face_normal_t want;
            if (pending_normals.size() == 0)
            begin
                unexpected++;
                if (unexpected + mismatches <= 10)
                    $display("error: normal with no request outstanding at %0t", $realtime);
                return;
            end
            want = pending_normals.pop_front();
            checked++;
            if (got.degenerate)
                degenerate_seen++;
            if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz ||
                got.degenerate !== want.degenerate)
            begin
                mismatches++;
                if (mismatches + unexpected <= 10)
                    $display("mismatch %0d: expected (%0d %0d %0d deg %0b) got (%0d %0d %0d deg %0b)",
                             checked, want.nx, want.ny, want.nz, want.degenerate,
                             got.nx, got.ny, got.nz, got.degenerate);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_fire;
    // when set neither side idles
    bit   steady;
    int   sent;

    normal_scoreboard sb;

    tfn_in_if  #(.COORD_BITS(CB))  corners_if();
    tfn_out_if #(.NORMAL_BITS(NB)) normal_if();

    triangle_face_normal #(.COORD_BITS(CB), .NORMAL_BITS(NB)) dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .corners (corners_if),
        .normal  (normal_if)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // acceptance of a request is seen on the rising edge, handed to the sender at the falling one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_fire <= 1'b0;
        else
        begin
            in_fire <= corners_if.valid && corners_if.ready;
            if (corners_if.valid && corners_if.ready)
            begin
                triangle_t t;
                t.p[0] = corners_if.corner_a_x;
                t.p[1] = corners_if.corner_a_y;
                t.p[2] = corners_if.corner_a_z;
                t.p[3] = corners_if.corner_b_x;
                t.p[4] = corners_if.corner_b_y;
                t.p[5] = corners_if.corner_b_z;
                t.p[6] = corners_if.corner_c_x;
                t.p[7] = corners_if.corner_c_y;
                t.p[8] = corners_if.corner_c_z;
                sb.note_request(t);
            end
        end
    end

    // every accepted normal is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && normal_if.valid && normal_if.ready)
        begin
            face_normal_t got;
            got.nx = normal_if.normal_x;
            got.ny = normal_if.normal_y;
            got.nz = normal_if.normal_z;
            got.degenerate = normal_if.degenerate;
            sb.check_normal(got);
        end
    end

    // sink drops ready at random about 31 percent of the time, except in the steady stretch
    always @(negedge clk)
        normal_if.ready = steady ? 1'b1 : ($urandom_range(99) >= 31);

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_triangle(triangle_t t);
        while (!steady && $urandom_range(99) < 31)
        begin
            corners_if.valid = 1'b0;
            @(negedge clk);
        end
        corners_if.valid = 1'b1;
        corners_if.corner_a_x = t.p[0];
        corners_if.corner_a_y = t.p[1];
        corners_if.corner_a_z = t.p[2];
        corners_if.corner_b_x = t.p[3];
        corners_if.corner_b_y = t.p[4];
        corners_if.corner_b_z = t.p[5];
        corners_if.corner_c_x = t.p[6];
        corners_if.corner_c_y = t.p[7];
        corners_if.corner_c_z = t.p[8];
        @(negedge clk);
        while (!in_fire)
            @(negedge clk);
        sent++;
    endtask

    task automatic send_corners(longint ax, longint ay, longint az, longint bx, longint by,
                                longint bz, longint cx, longint cy, longint cz);
        triangle_t t;
        t.p[0] = coord_t'(ax);
        t.p[1] = coord_t'(ay);
        t.p[2] = coord_t'(az);
        t.p[3] = coord_t'(bx);
        t.p[4] = coord_t'(by);
        t.p[5] = coord_t'(bz);
        t.p[6] = coord_t'(cx);
        t.p[7] = coord_t'(cy);
        t.p[8] = coord_t'(cz);
        send_triangle(t);
    endtask

    function automatic longint span_rand(int half);
        return longint'($urandom_range(2 * half)) - half;
    endfunction

    // random triangle of one of several shapes
    task automatic send_random_triangle();
        triangle_t t;
        longint a[3];
        longint d[3];
        longint s;
        int kind;
        int pick;
        kind = $urandom_range(99);
        pick = $urandom_range(1, 2);
        for (int i = 0; i < 9; i++)
            t.p[i] = coord_t'($urandom());
        if (kind < 35)
        begin
            // full range coordinates, every bit free
        end
        else if (kind < 60)
        begin
            // small triangle near a random point
            for (int i = 0; i < 3; i++)
            begin
                a[i] = span_rand(1 << 22);
                t.p[i] = coord_t'(a[i]);
                t.p[3+i] = coord_t'(a[i] + span_rand(1 << $urandom_range(12)));
                t.p[6+i] = coord_t'(a[i] + span_rand(1 << $urandom_range(12)));
            end
        end
        else if (kind < 75)
        begin
            // collinear corners, degenerate
            s = span_rand(500);
            for (int i = 0; i < 3; i++)
            begin
                a[i] = span_rand(1 << 20);
                d[i] = span_rand(1 << 10);
                t.p[i] = coord_t'(a[i]);
                t.p[3+i] = coord_t'(a[i] + d[i]);
                t.p[6+i] = coord_t'(a[i] + s * d[i]);
            end
        end
        else if (kind < 85)
        begin
            // two corners coincide
            for (int i = 0; i < 3; i++)
                t.p[3 * pick + i] = t.p[i];
        end
        else
        begin
            // triangle in an axis plane, two normal components zero
            for (int i = 0; i < 3; i++)
            begin
                t.p[3+kind%3] = t.p[kind%3];
                t.p[6+kind%3] = t.p[kind%3];
            end
        end
        send_triangle(t);
    endtask

    localparam longint CMAX = (longint'(1) << (CB - 1)) - 1;
    localparam longint CMIN = -(longint'(1) << (CB - 1));

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        steady = 1'b0;
        sent = 0;
        corners_if.valid = 1'b0;
        corners_if.corner_a_x = '0;
        corners_if.corner_a_y = '0;
        corners_if.corner_a_z = '0;
        corners_if.corner_b_x = '0;
        corners_if.corner_b_y = '0;
        corners_if.corner_b_z = '0;
        corners_if.corner_c_x = '0;
        corners_if.corner_c_y = '0;
        corners_if.corner_c_z = '0;
        normal_if.ready = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: zeros, extremes, axis aligned, degenerate and tiny negative components
        send_corners(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_corners(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        send_corners(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
        send_corners(0, 0, 0, 1, 0, 0, 0, 1, 0);
        send_corners(0, 0, 0, 0, 1, 0, 1, 0, 0);
        send_corners(0, 0, 0, 0, 0, 1, 1, 0, 0);
        send_corners(0, 0, 0, 0, 1, 0, 0, 0, 1);
        send_corners(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN);
        send_corners(CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX);
        send_corners(CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX);
        send_corners(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN);
        send_corners(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX);
        send_corners(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, 0);
        send_corners(5, 7, 9, 5, 7, 9, -3, 2, 8);
        send_corners(1, 2, 3, 2, 4, 6, 3, 6, 9);
        send_corners(0, 0, 0, 1000000, 0, 0, 0, 1000000, 1);
        send_corners(0, 0, 0, 1000000, 0, 0, 0, 1000000, -1);
        send_corners(0, 0, 0, -1, 1000000, 0, 0, 0, 1000000);
        send_corners(0, 0, 0, 1, 1, 0, 1, 1, 1);
        send_corners(-1, -1, -1, 0, -1, -1, -1, 0, -1);
        send_corners(CMAX, 0, 0, 0, CMAX, 0, 0, 0, CMAX);
        send_corners(CMIN, 0, 0, 0, CMIN, 0, 0, 0, CMIN);
        send_corners(3, -4, 0, 3, -4, 0, 3, -4, 0);

        // random part with a stretch of back to back traffic in the middle
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            steady = (i >= 700 && i < 1000);
            send_random_triangle();
        end
        steady = 1'b0;
        corners_if.valid = 1'b0;

        while (sb.pending_normals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d triangles, checked %0d normals, %0d of them degenerate",
                 sent, sb.checked, sb.degenerate_seen);
        $display("mismatches %0d, unexpected normals %0d", sb.mismatches, sb.unexpected);
        if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending_normals.size() == 0)
            $display("triangle_face_normal test passed");
        else
            $display("triangle_face_normal test failed");
        $finish;
    end

    // overall limit, well beyond the slowest correct run
    initial
    begin
        #2ms;
        $display("triangle_face_normal test failed");
        $finish;
    end

endmodule

@@ sim.f @@
sv/tfn_pkg.sv
sv/tfn_in_if.sv
sv/tfn_out_if.sv
sv/triangle_face_normal.sv
tb/tb.sv
